/* design/irpfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfd_pkg
// Shared types and constants for the IR pulse frame decoder.
// ----------------------------------------------------------------------------
package irpfd_pkg;

    // Input transaction: edge capture or timer overflow
    typedef struct packed {
        logic        event_kind;
        logic [15:0] interval;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic        frame_ready;
        logic        address_ok;
        logic [7:0]  command;
        logic [15:0] address;
    } t_out_item;

    // Event class passed from front to back
    typedef logic [1:0] t_cls;

    localparam t_cls CLS_ZERO    = 2'd0;  // shift in a 0
    localparam t_cls CLS_ONE     = 2'd1;  // shift in a 1
    localparam t_cls CLS_RESTART = 2'd2;  // clear the bit count
    localparam t_cls CLS_IGNORE  = 2'd3;  // leave the state alone

    localparam logic EVT_CAPTURE  = 1'b0;
    localparam logic EVT_OVERFLOW = 1'b1;

    // Unit codes of interest
    localparam int UNIT_ZERO   = 1;
    localparam int UNIT_ONE    = 2;
    localparam int UNIT_LEADER = 13;
    localparam int UNIT_MIN    = 9;
    localparam int UNIT_MAX    = 96;

    // Wide enough for (UNIT_MAX + 1) * 65535
    localparam int THR_W = 24;

    localparam int          BIT_CNT_W = 8;
    localparam int          ADDR_BITS = 16;
    localparam logic [15:0] EXPECTED_ADDR_RESET = 16'hFF00;

    // Configuration register map
    localparam int          PADDR_W      = 3;
    localparam logic        REG_EXPECTED = 1'b0;  // word index of expected_address
    localparam int          PDATA_W      = 32;

endpackage

/* design/irpfd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfd_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface irpfd_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/ir_pulse_frame_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_frame_decoder_core
// NEC-style IR remote frame decoder with APB address register.
// ----------------------------------------------------------------------------
// Feed one transaction per receiver edge (interval in timer ticks) or per
// timer overflow; every input transaction yields exactly one result
// transaction carrying frame_ready, address_ok, command and the latched
// address. The block sustains one transaction per clock cycle while the
// output side does not stall: the front classifies an interval against
// fixed multiples of UNIT_TICKS, and the back updates the bit count and
// shift register for each event it takes. Each result passes through the
// front register, which loads at the accepting edge, then a queue slot,
// then the output register, where it is held while the output side stalls.
// The two-entry queue lets the front keep taking input while a result waits
// on the output. The expected address lives at byte address 0 of the APB
// port (reset 0xFF00); write it only while the decoder is idle.
// ----------------------------------------------------------------------------
module ir_pulse_frame_decoder_core #(
    parameter int UNIT_TICKS = 375,
    parameter int FRAME_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    irpfd_if.sink                           i_in,
    irpfd_if.source                         o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [irpfd_pkg::PADDR_W-1:0]   paddr,
    input  logic [irpfd_pkg::PDATA_W-1:0]   pwdata,
    output logic [irpfd_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);
    import irpfd_pkg::*;

    logic [15:0] r_expected;
    logic        cfg_write;

    // Front to queue, queue to back
    irpfd_if #(.t_payload(t_cls)) cls_front ();
    irpfd_if #(.t_payload(t_cls)) cls_back ();

    // Register access: word index is paddr[2], byte lanes ignored
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= EXPECTED_ADDR_RESET;
        end else if (cfg_write && paddr[2] == REG_EXPECTED) begin
            r_expected <= pwdata[15:0];
        end
    end

    // Return zero for addresses past the register list
    always_comb begin
        if (paddr[2] == REG_EXPECTED) begin
            prdata = PDATA_W'(r_expected);
        end else begin
            prdata = '0;
        end
    end

    // Classify incoming transactions
    irpfd_front #(
        .UNIT_TICKS (UNIT_TICKS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cls   (cls_front.source)
    );

    // Decouple front and back
    irpfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cls_front.sink),
        .o_pop   (cls_back.source)
    );

    // Advance the frame state and drive results
    irpfd_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_expected (r_expected),
        .i_cls      (cls_back.sink),
        .o_out      (o_out)
    );

endmodule

/* design/irpfd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfd_front
// Accept input transactions and classify each into a bit, restart or ignore.
// ----------------------------------------------------------------------------
module irpfd_front #(
    parameter int UNIT_TICKS = 375
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    irpfd_if.sink  i_in,
    irpfd_if.source o_cls
);
    import irpfd_pkg::*;

    // Interval thresholds for the unit boundaries (unit = interval / UNIT_TICKS)
    localparam logic [THR_W-1:0] T_ONE    = THR_W'(UNIT_ZERO * UNIT_TICKS);
    localparam logic [THR_W-1:0] T_TWO    = THR_W'(UNIT_ONE * UNIT_TICKS);
    localparam logic [THR_W-1:0] T_THREE  = THR_W'((UNIT_ONE + 1) * UNIT_TICKS);
    localparam logic [THR_W-1:0] T_LEAD   = THR_W'(UNIT_LEADER * UNIT_TICKS);
    localparam logic [THR_W-1:0] T_LEAD1  = THR_W'((UNIT_LEADER + 1) * UNIT_TICKS);
    localparam logic [THR_W-1:0] T_MIN    = THR_W'(UNIT_MIN * UNIT_TICKS);
    localparam logic [THR_W-1:0] T_ABOVE  = THR_W'((UNIT_MAX + 1) * UNIT_TICKS);

    logic             r_valid;
    t_cls             r_cls;
    t_cls             n_cls;
    logic [THR_W-1:0] ticks;
    logic             take;

    assign ticks = THR_W'(i_in.payload.interval);

    always_comb begin
        if (i_in.payload.event_kind == EVT_OVERFLOW) begin
            n_cls = CLS_RESTART;
        end else if (ticks >= T_ONE && ticks < T_TWO) begin
            n_cls = CLS_ZERO;
        end else if (ticks >= T_TWO && ticks < T_THREE) begin
            n_cls = CLS_ONE;
        end else if ((ticks >= T_LEAD && ticks < T_LEAD1) || ticks < T_MIN ||
                     ticks >= T_ABOVE) begin
            n_cls = CLS_RESTART;
        end else begin
            n_cls = CLS_IGNORE;
        end
    end

    // Hold the classified event until the queue takes it
    assign i_in.ready    = !r_valid || o_cls.ready;
    assign take          = i_in.valid && i_in.ready;
    assign o_cls.valid   = r_valid;
    assign o_cls.payload = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cls <= n_cls;
        end
    end

endmodule

/* design/irpfd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfd_queue
// Two-entry queue of event classes between front and back.
// ----------------------------------------------------------------------------
module irpfd_queue (
    input  logic    i_clk,
    input  logic    i_rst_n,
    irpfd_if.sink   i_push,
    irpfd_if.source o_pop
);
    import irpfd_pkg::*;

    t_cls       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign i_push.ready  = (r_count != 2'd2);
    assign o_pop.valid   = (r_count != 2'd0);
    assign o_pop.payload = r_mem[r_rd_ptr];
    assign push          = i_push.valid && i_push.ready;
    assign pop           = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.payload;
        end
    end

endmodule

/* design/irpfd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfd_back
// Apply classified events to the frame state and register each result.
// ----------------------------------------------------------------------------
module irpfd_back #(
    parameter int FRAME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_expected,
    irpfd_if.sink       i_cls,
    irpfd_if.source     o_out
);
    import irpfd_pkg::*;

    localparam logic [BIT_CNT_W-1:0] FRAME_CNT = BIT_CNT_W'(FRAME_BITS);
    localparam logic [BIT_CNT_W-1:0] ADDR_CNT  = BIT_CNT_W'(ADDR_BITS);

    logic [BIT_CNT_W-1:0] r_bit_count;
    logic [15:0]          r_shift;
    logic [15:0]          r_latch;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [BIT_CNT_W-1:0] cnt_upd;
    logic [BIT_CNT_W-1:0] n_bit_count;
    logic [15:0]          n_shift;
    logic [15:0]          n_latch;
    logic                 at_frame;
    logic                 check_ok;
    logic                 pop;

    // Step the frame state for one event
    always_comb begin
        cnt_upd = r_bit_count;
        n_shift = r_shift;
        case (i_cls.payload)
            CLS_ZERO: begin
                n_shift = {1'b0, r_shift[15:1]};
                cnt_upd = r_bit_count + 1'b1;
            end
            CLS_ONE: begin
                n_shift = {1'b1, r_shift[15:1]};
                cnt_upd = r_bit_count + 1'b1;
            end
            CLS_RESTART: begin
                cnt_upd = '0;
            end
            default: begin
                cnt_upd = r_bit_count;
            end
        endcase

        // Latch the address word once sixteen bits are in
        n_latch  = (cnt_upd == ADDR_CNT) ? n_shift : r_latch;

        // Command byte must be the complement of its partner
        at_frame = (cnt_upd == FRAME_CNT);
        check_ok = (n_shift[15:8] == ~n_shift[7:0]);
        n_bit_count = (at_frame && !check_ok) ? '0 : cnt_upd;
    end

    assign i_cls.ready   = !r_out_valid || o_out.ready;
    assign pop           = i_cls.valid && i_cls.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= '0;
            r_shift     <= '0;
            r_latch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_bit_count <= n_bit_count;
                r_shift     <= n_shift;
                r_latch     <= n_latch;
            end
            if (i_cls.ready) begin
                r_out_valid <= i_cls.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.frame_ready <= at_frame && check_ok;
            r_out.address_ok  <= (n_latch == i_expected);
            r_out.command     <= n_shift[7:0];
            r_out.address     <= n_latch;
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IR pulse frame decoder. Directed table of
// boundary intervals, then random well-formed remote frames with random
// content, corrupted and truncated frames and raw noise, all scored against
// a cycle-free decoder model under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import irpfd_pkg::*;

    localparam int UNIT_TICKS     = 375;
    localparam int FRAME_BITS     = 32;
    localparam int NUM_SEGMENTS   = 6;
    localparam int SEG_ITEMS      = 320;
    localparam int STALL_CYCLES   = 80;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_RUN_BITS  = 300;
    localparam int NUM_ROWS       = 18;

    localparam logic [PADDR_W-1:0] EXP_ADDR_BYTE = PADDR_W'(4 * REG_EXPECTED);

    // One row of the directed table; want is only used when typed is set
    typedef struct {
        logic        kind;
        logic [15:0] ticks;
        bit          typed;
        t_out_item   want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    irpfd_if #(.t_payload(t_in_item))  in_ch ();
    irpfd_if #(.t_payload(t_out_item)) out_ch ();

    ir_pulse_frame_decoder_core #(
        .UNIT_TICKS (UNIT_TICKS),
        .FRAME_BITS (FRAME_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Decoder model state and its copy of the address register
    logic [BIT_CNT_W-1:0] dec_bits;
    logic [15:0]          dec_shift;
    logic [15:0]          dec_addr_latch;
    logic [15:0]          dec_expected;

    t_out_item pending_results [$];
    int        fail_count;
    int        sent_count;
    int        seg_idx;
    int        idle_cycles;

    // Directed table: state is all zero after reset and the register holds
    // its reset value, so every restart or ignored unit leaves a zero result.
    t_stim_row stim_table [NUM_ROWS] = '{
        '{EVT_OVERFLOW, 16'd0,     1'b1, '0},  // overflow straight after reset
        '{EVT_CAPTURE,  16'd0,     1'b1, '0},  // zero units: restart
        '{EVT_CAPTURE,  16'd65535, 1'b1, '0},  // top of range: restart
        '{EVT_CAPTURE,  16'd4875,  1'b1, '0},  // leader unit: restart
        '{EVT_CAPTURE,  16'd3375,  1'b1, '0},  // lowest ignored unit
        '{EVT_CAPTURE,  16'd36374, 1'b1, '0},  // highest ignored unit
        '{EVT_CAPTURE,  16'd36375, 1'b1, '0},  // first unit above ignore band
        '{EVT_CAPTURE,  16'd3374,  1'b1, '0},  // just under ignore band
        '{EVT_CAPTURE,  16'd1125,  1'b1, '0},  // unit three: restart
        '{EVT_CAPTURE,  16'd375,   1'b0, '0},  // lowest zero bit
        '{EVT_CAPTURE,  16'd1124,  1'b0, '0},  // highest one bit
        '{EVT_CAPTURE,  16'd749,   1'b0, '0},  // highest zero bit
        '{EVT_CAPTURE,  16'd750,   1'b0, '0},  // lowest one bit
        '{EVT_CAPTURE,  16'd9000,  1'b0, '0},  // repeat leader: hold state
        '{EVT_CAPTURE,  16'd5000,  1'b0, '0},  // leader mid-unit
        '{EVT_CAPTURE,  16'd1000,  1'b0, '0},
        '{EVT_OVERFLOW, 16'hFFFF,  1'b0, '0},  // overflow ignores interval
        '{EVT_CAPTURE,  16'd21845, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Decoder model: advance state by one event and return its result
    // ------------------------------------------------------------------------
    function automatic t_out_item decode_event(input t_in_item it);
        int unsigned units;
        t_out_item   res;
        res = '0;
        if (it.event_kind == EVT_CAPTURE) begin
            units = it.interval / UNIT_TICKS;
            if (units == UNIT_ZERO || units == UNIT_ONE) begin
                dec_shift = {units == UNIT_ONE, dec_shift[15:1]};
                dec_bits  = dec_bits + 1'b1;
            end else if (units == UNIT_LEADER || units < UNIT_MIN || units > UNIT_MAX) begin
                dec_bits = '0;
            end
            if (dec_bits == ADDR_BITS) begin
                dec_addr_latch = dec_shift;
            end
        end else begin
            dec_bits = '0;
        end
        // Command byte and its complement must agree, else drop the frame now
        if (dec_bits == FRAME_BITS) begin
            if (dec_shift[15:8] != ~dec_shift[7:0]) begin
                dec_bits = '0;
            end else begin
                res.frame_ready = 1'b1;
            end
        end
        res.address_ok = (dec_addr_latch == dec_expected);
        res.command    = dec_shift[7:0];
        res.address    = dec_addr_latch;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Idle profile: sender-light first, then receiver-light, then none
    // ------------------------------------------------------------------------
    function automatic int gap_profile(input int seg);
        if (seg <= 2) begin
            return 0;
        end else if (seg <= 4) begin
            return 1;
        end
        return 2;
    endfunction

    function automatic int sender_idle_pct();
        case (gap_profile(seg_idx))
            0:       return 8;
            1:       return 52;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (gap_profile(seg_idx))
            0:       return 52;
            1:       return 8;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Every task starts and ends at a falling edge, so valid
    // only ever gets one assignment per time step.
    // ------------------------------------------------------------------------
    task automatic send_event(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(99) < sender_idle_pct()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        // Model always advances; typed rows override what gets scored
        predicted = decode_event(it);
        pending_results.push_back(typed ? want : predicted);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic send_capture(input logic [15:0] ticks);
        send_event('{event_kind: EVT_CAPTURE, interval: ticks}, 1'b0, '0);
    endtask

    task automatic send_overflow();
        send_event('{event_kind: EVT_OVERFLOW, interval: 16'($urandom)}, 1'b0, '0);
    endtask

    // Random interval that quantizes to the given unit count
    function automatic logic [15:0] unit_ticks(input int units);
        return 16'(units * UNIT_TICKS + $urandom_range(UNIT_TICKS - 1));
    endfunction

    function automatic logic [15:0] restart_ticks();
        case ($urandom_range(3))
            0:       return unit_ticks(0);
            1:       return unit_ticks($urandom_range(3, 8));
            2:       return unit_ticks(UNIT_LEADER);
            default: return unit_ticks($urandom_range(UNIT_MAX + 1, 173));
        endcase
    endfunction

    function automatic logic [15:0] hold_ticks();
        int units;
        do units = $urandom_range(UNIT_MIN, UNIT_MAX); while (units == UNIT_LEADER);
        return unit_ticks(units);
    endfunction

    function automatic logic [15:0] bit_ticks(input logic value);
        return unit_ticks(value ? UNIT_ONE : UNIT_ZERO);
    endfunction

    // Full remote frame: leader, address LSB first, command, inverted command
    task automatic send_frame();
        logic [15:0] addr;
        logic [7:0]  cmd;
        logic [7:0]  inv;
        logic [31:0] word;
        int          repeats;
        addr = ($urandom_range(9) < 7) ? dec_expected : 16'($urandom);
        cmd  = 8'($urandom);
        inv  = ~cmd;
        // Spoil the complement now and then to exercise the early drop
        if ($urandom_range(4) == 0) begin
            inv = inv ^ 8'($urandom_range(1, 255));
        end
        word = {inv, cmd, addr};
        send_capture(unit_ticks(UNIT_LEADER));
        for (int b = 0; b < 32; b++) begin
            send_capture(bit_ticks(word[b]));
        end
        // Held key: repeat leaders must leave a ready frame standing
        repeats = $urandom_range(3);
        for (int r = 0; r < repeats; r++) begin
            send_capture(hold_ticks());
        end
        if ($urandom_range(9) < 3) begin
            send_overflow();
        end
    endtask

    // Frame cut short by an overflow, a restart unit, or nothing at all
    task automatic send_broken_frame();
        int nbits;
        nbits = $urandom_range(1, 31);
        send_capture(unit_ticks(UNIT_LEADER));
        for (int b = 0; b < nbits; b++) begin
            send_capture(bit_ticks(1'($urandom_range(1))));
        end
        case ($urandom_range(2))
            0:       send_overflow();
            1:       send_capture(restart_ticks());
            default: ;
        endcase
    endtask

    task automatic send_noise(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0) begin
                send_overflow();
            end else begin
                send_capture(16'($urandom));
            end
        end
    endtask

    // Data run past the frame end, long enough for the bit count to wrap;
    // a second valid command pair sits where the wrapped count hits the
    // frame length again, and the address is relatched on the way.
    task automatic send_long_run();
        logic [LONG_RUN_BITS-1:0] stream;
        logic [7:0]               cmd;
        logic [7:0]               cmd2;
        cmd  = 8'($urandom);
        cmd2 = 8'($urandom);
        for (int b = 0; b < LONG_RUN_BITS; b++) begin
            stream[b] = 1'($urandom_range(1));
        end
        stream[31:0]    = {~cmd, cmd, dec_expected};
        stream[279:272] = cmd2;
        stream[287:280] = ~cmd2;
        send_capture(unit_ticks(UNIT_LEADER));
        for (int b = 0; b < LONG_RUN_BITS; b++) begin
            send_capture(bit_ticks(stream[b]));
        end
    endtask

    task automatic run_random_segment(input bit with_long_run);
        int start;
        int pick;
        start = sent_count;
        if (with_long_run) begin
            send_long_run();
        end
        while (sent_count - start < SEG_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_frame();
            end else if (pick < 80) begin
                send_broken_frame();
            end else begin
                send_noise($urandom_range(1, 8));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Register port: setup, access, then psel drops between accesses
    // ------------------------------------------------------------------------
    task automatic apb_access(input logic write, input logic [15:0] value,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= EXP_ADDR_BYTE;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_register(input logic [15:0] value);
        logic [PDATA_W-1:0] rdata;
        apb_access(1'b0, '0, rdata);
        if (rdata !== PDATA_W'(value)) begin
            $display("%0t: expected_address readback expected %h actual %h",
                     $time, PDATA_W'(value), rdata);
            fail_count++;
        end
    endtask

    task automatic write_expected(input logic [15:0] value);
        logic [PDATA_W-1:0] rdata;
        apb_access(1'b1, value, rdata);
        dec_expected = value;
        check_register(value);
    endtask

    // Drop valid, wait out every pending result, then let the pipe go quiet
    task automatic settle_decoder();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [15:0] reg_value;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        fail_count    = 0;
        sent_count    = 0;
        seg_idx       = 0;
        dec_bits       = '0;
        dec_shift      = '0;
        dec_addr_latch = '0;
        dec_expected   = EXPECTED_ADDR_RESET;

        // Hold reset, release on a falling edge
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        check_register(EXPECTED_ADDR_RESET);

        foreach (stim_table[r]) begin
            send_event('{event_kind: stim_table[r].kind, interval: stim_table[r].ticks},
                       stim_table[r].typed, stim_table[r].want);
        end

        // Each segment reprograms the address while idle, then runs random
        // traffic; the receiver opens every segment with a long stall.
        for (int s = 0; s < NUM_SEGMENTS; s++) begin
            settle_decoder();
            case (s)
                0:       reg_value = 16'h0000;
                1:       reg_value = 16'hFFFF;
                2:       reg_value = EXPECTED_ADDR_RESET;
                default: reg_value = 16'($urandom);
            endcase
            write_expected(reg_value);
            seg_idx <= s + 1;
            run_random_segment(s == 3);
        end

        settle_decoder();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: random ready, with a counted stall at each segment start
    // so the queue fills and the input gets pushed back.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int last_seg;
        int stall_left;
        out_ch.ready = 1'b0;
        last_seg     = -1;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (seg_idx != last_seg) begin
                last_seg   = seg_idx;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: compare each result transaction with the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h",
                         $time, out_ch.payload);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("frame_ready", 16'(want.frame_ready), 16'(out_ch.payload.frame_ready));
                check_field("address_ok",  16'(want.address_ok),  16'(out_ch.payload.address_ok));
                check_field("command",     16'(want.command),     16'(out_ch.payload.command));
                check_field("address",     want.address,          out_ch.payload.address);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transaction on either channel
    // ------------------------------------------------------------------------
    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* ir_pulse_frame_decoder_core.f */
design/irpfd_pkg.sv
design/irpfd_if.sv
design/irpfd_front.sv
design/irpfd_queue.sv
design/irpfd_back.sv
design/ir_pulse_frame_decoder_core.sv
bench/testbench.sv
